FILE: rtl/rsi_pkg.sv
// shared types and constants of the relative strength index block
package rsi_pkg;

    localparam int WIN_W        = 9;
    localparam int MAX_WINDOW   = 256;
    localparam int MIN_WINDOW   = 2;
    localparam int WINDOW_RESET = 14;

    localparam int SAMPLE_W = 32;
    localparam int MAG_W    = 32;
    localparam int AVG_W    = 48;
    localparam int PROD_W   = 63;
    localparam int DVD_W    = 64;
    localparam int REM_W    = 49;
    localparam int RSI_W    = 15;
    localparam int MUL_B_W  = 15;
    localparam int ITER_W   = 6;

    localparam logic [RSI_W-1:0]  RSI_FULL    = RSI_W'(25600);
    localparam logic [ITER_W-1:0] WARM_ITER   = ITER_W'(57);
    localparam logic [ITER_W-1:0] SMOOTH_ITER = ITER_W'(48);
    localparam logic [ITER_W-1:0] RSI_ITER    = ITER_W'(15);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_RSI_MUL,
        S_RSI_START,
        S_RSI_WAIT,
        S_OUT
    } rsi_state_t;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iterations;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

FILE: rtl/rsi_divider.sv
// shared restoring divider, one quotient bit per cycle
module rsi_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rsi_pkg::div_cmd_t         cmd,
    input  logic [rsi_pkg::REM_W-1:0] divisor,
    input  logic [rsi_pkg::REM_W-1:0] rem_init,
    input  logic [rsi_pkg::DVD_W-1:0] dvd_init,
    output rsi_pkg::div_sts_t         sts,
    output logic [rsi_pkg::DVD_W-1:0] quotient
);
    import rsi_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] count_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [REM_W-1:0]  divisor_reg;

    logic [REM_W:0]    cand;
    logic [REM_W:0]    diff;
    logic              q_bit;

    assign cand  = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = cand - {1'b0, divisor_reg};
    assign q_bit = (cand >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= cmd.iterations;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - ITER_W'(1);
                if (count_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg     <= rem_init;
            dvd_reg     <= dvd_init;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? diff[REM_W-1:0] : cand[REM_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: rtl/relative_strength_index.sv
// relative strength index with wilder smoothing, top level and sequencer
//
// One sample is taken per request while the block is idle. The first sample of a series
// and the warm-up samples before the last one give no result. Every sample that gives a
// result runs two divisions by the window length and one ratio division through a single
// shared divider that makes one quotient bit per cycle: SMOOTH_ITER divider steps for each
// smoothing division in steady state, WARM_ITER for each first average at the last warm-up
// sample and RSI_ITER for the ratio. When the average loss is zero the ratio division is
// skipped. A finished result waits in the output register while the next sample is
// already taken; the block holds its last step only when that register is still full. A
// write on the config channel sets the window length, clamped to 2..256, and starts a new
// series with the next sample.
module relative_strength_index (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,       // window_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample
    input  logic        s_axis_tuser,   // series_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // rsi_value, zero pad
    output logic        m_axis_tuser    // no_loss
);
    import rsi_pkg::*;

    rsi_state_t state_reg;
    rsi_state_t state_next;

    logic [WIN_W-1:0]           n_reg;
    logic [WIN_W-1:0]           count_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       start_reg;
    logic [AVG_W-1:0]           gain_avg_reg;
    logic [AVG_W-1:0]           loss_avg_reg;
    logic [MAG_W-1:0]           gain_reg;
    logic [MAG_W-1:0]           loss_reg;
    logic                       warm_reg;
    logic                       sel_loss_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [REM_W-1:0]           tsum_reg;
    logic                       out_valid_reg;
    logic [RSI_W-1:0]           out_rsi_reg;
    logic                       out_noloss_reg;
    logic [RSI_W-1:0]           res_rsi_reg;
    logic                       res_noloss_reg;

    logic                       in_accept;
    logic                       new_series;
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W:0]          neg_diff;
    logic [MAG_W-1:0]           gain_now;
    logic [MAG_W-1:0]           loss_now;
    logic [WIN_W:0]             count_inc;
    logic                       warm_phase;
    logic [AVG_W-1:0]           avg_sel;
    logic [MAG_W-1:0]           x_sel;
    logic [AVG_W-1:0]           mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [PROD_W-1:0]          mul_p;
    logic [56:0]                smooth_num;
    logic [DVD_W-1:0]           rsi_num;
    logic                       out_free;
    logic [WIN_W-1:0]           cfg_clamped;

    div_cmd_t                   div_cmd;
    div_sts_t                   div_sts;
    logic [REM_W-1:0]           div_divisor;
    logic [REM_W-1:0]           div_rem_init;
    logic [DVD_W-1:0]           div_dvd_init;
    logic [DVD_W-1:0]           div_quotient;

    rsi_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .divisor  (div_divisor),
        .rem_init (div_rem_init),
        .dvd_init (div_dvd_init),
        .sts      (div_sts),
        .quotient (div_quotient)
    );

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign new_series = start_reg || (count_reg == '0);
    assign diff       = {sample_reg[SAMPLE_W-1], sample_reg} - {prev_reg[SAMPLE_W-1], prev_reg};
    assign neg_diff   = -diff;
    assign gain_now   = (diff > 0) ? diff[MAG_W-1:0] : '0;
    assign loss_now   = (diff < 0) ? neg_diff[MAG_W-1:0] : '0;
    assign count_inc  = {1'b0, count_reg} + (WIN_W+1)'(1);
    assign warm_phase = (count_reg < n_reg);
    assign avg_sel    = sel_loss_reg ? loss_avg_reg : gain_avg_reg;
    assign x_sel      = sel_loss_reg ? loss_reg : gain_reg;
    assign mul_p      = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign smooth_num = prod_reg[56:0] + {9'b0, x_sel, 16'b0};
    assign rsi_num    = {1'b0, prod_reg} + DVD_W'(tsum_reg >> 1);
    assign out_free   = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        cfg_clamped = cfg_data;
        if (cfg_data < WIN_W'(MIN_WINDOW))
        begin
            cfg_clamped = WIN_W'(MIN_WINDOW);
        end
        else if (cfg_data > WIN_W'(MAX_WINDOW))
        begin
            cfg_clamped = WIN_W'(MAX_WINDOW);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (new_series)
                begin
                    state_next = S_IDLE;
                end
                else if (warm_phase)
                begin
                    state_next = (count_inc < {1'b0, n_reg}) ? S_IDLE : S_DIV_START;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_sts.done)
                begin
                    if (sel_loss_reg)
                    begin
                        state_next = S_RSI_MUL;
                    end
                    else
                    begin
                        state_next = warm_reg ? S_DIV_START : S_MUL;
                    end
                end
            end
            S_RSI_MUL:
            begin
                state_next = (loss_avg_reg == '0) ? S_OUT : S_RSI_START;
            end
            S_RSI_START:
            begin
                state_next = S_RSI_WAIT;
            end
            S_RSI_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready      = 1'b0;
        div_cmd.start      = 1'b0;
        div_cmd.iterations = SMOOTH_ITER;
        div_divisor        = REM_W'(n_reg);
        div_rem_init       = '0;
        div_dvd_init       = '0;
        mul_a              = avg_sel;
        mul_b              = MUL_B_W'(n_reg - WIN_W'(1));
        unique case (state_reg) inside
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_DIV_START:
            begin
                div_cmd.start = 1'b1;
                if (warm_reg)
                begin
                    div_cmd.iterations = WARM_ITER;
                    div_dvd_init       = {avg_sel[40:0], 23'b0};
                end
                else
                begin
                    div_rem_init = REM_W'(smooth_num[56:48]);
                    div_dvd_init = {smooth_num[47:0], 16'b0};
                end
            end
            S_RSI_MUL:
            begin
                mul_a = gain_avg_reg;
                mul_b = RSI_FULL;
            end
            S_RSI_START:
            begin
                div_cmd.start      = 1'b1;
                div_cmd.iterations = RSI_ITER;
                div_divisor        = tsum_reg;
                div_rem_init       = rsi_num[DVD_W-1:RSI_W];
                div_dvd_init       = {rsi_num[RSI_W-1:0], (DVD_W-RSI_W)'(0)};
            end
            S_PREP, S_MUL, S_DIV_WAIT, S_RSI_WAIT, S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= WIN_W'(WINDOW_RESET);
            count_reg     <= '0;
            prev_reg      <= '0;
            gain_avg_reg  <= '0;
            loss_avg_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                n_reg     <= cfg_clamped;
                count_reg <= '0;
            end
            unique case (state_reg)
                S_PREP:
                begin
                    prev_reg <= sample_reg;
                    if (new_series)
                    begin
                        count_reg    <= WIN_W'(1);
                        gain_avg_reg <= '0;
                        loss_avg_reg <= '0;
                    end
                    else if (warm_phase)
                    begin
                        count_reg    <= count_inc[WIN_W-1:0];
                        gain_avg_reg <= gain_avg_reg + AVG_W'(gain_now);
                        loss_avg_reg <= loss_avg_reg + AVG_W'(loss_now);
                    end
                    else
                    begin
                        count_reg <= n_reg;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_sts.done)
                    begin
                        if (sel_loss_reg)
                        begin
                            loss_avg_reg <= div_quotient[AVG_W-1:0];
                        end
                        else
                        begin
                            gain_avg_reg <= div_quotient[AVG_W-1:0];
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= s_axis_tdata;
            start_reg  <= s_axis_tuser;
        end
        unique case (state_reg)
            S_PREP:
            begin
                gain_reg     <= gain_now;
                loss_reg     <= loss_now;
                warm_reg     <= warm_phase;
                sel_loss_reg <= 1'b0;
            end
            S_MUL:
            begin
                prod_reg <= mul_p;
            end
            S_DIV_WAIT:
            begin
                if (div_sts.done)
                begin
                    sel_loss_reg <= 1'b1;
                end
            end
            S_RSI_MUL:
            begin
                prod_reg       <= mul_p;
                tsum_reg       <= REM_W'(gain_avg_reg) + REM_W'(loss_avg_reg);
                res_rsi_reg    <= RSI_FULL;
                res_noloss_reg <= 1'b1;
            end
            S_RSI_WAIT:
            begin
                if (div_sts.done)
                begin
                    res_rsi_reg    <= div_quotient[RSI_W-1:0];
                    res_noloss_reg <= 1'b0;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_rsi_reg    <= res_rsi_reg;
                    out_noloss_reg <= res_noloss_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_rsi_reg};
    assign m_axis_tuser  = out_noloss_reg;

`ifndef NO_ASSERTIONS
    a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14:0] <= RSI_FULL))
        else $error("rsi value above full scale");

    a_noloss_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[14:0] == RSI_FULL))
        else $error("no-loss result not at full scale");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= n_reg)
        else $error("sample count beyond window");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_DIV_WAIT || state_reg == S_RSI_WAIT))
        else $error("divider finished outside a wait state");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> !div_sts.busy)
        else $error("divider restarted while busy");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the relative strength index block, random and directed samples
module testbench;
    import rsi_pkg::*;

    localparam int CLOCK_LIMIT    = 1000000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam logic [63:0] AVG_MASK = (64'd1 << AVG_W) - 64'd1;

    typedef struct {
        logic [SAMPLE_W-1:0] price;
        logic                series_start;
        bit                  wait_drain;
    } sample_req_t;

    typedef struct {
        logic [RSI_W-1:0] rsi_value;
        logic             no_loss;
    } rsi_result_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [WIN_W-1:0]    cfg_data      = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;
    logic                m_axis_tuser;

    sample_req_t pending_samples[$];
    rsi_result_t expected_rsi[$];
    sample_req_t next_request;
    rsi_result_t next_expected;

    int requests_queued   = 0;
    int requests_accepted = 0;
    int mismatches        = 0;
    int cycle_count       = 0;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    // predictor state
    logic [WIN_W-1:0]           window_reg = WIN_W'(WINDOW_RESET);
    logic signed [SAMPLE_W-1:0] last_price = '0;
    int unsigned                series_len = 0;
    logic [63:0]                gain_avg   = '0;
    logic [63:0]                loss_avg   = '0;

    relative_strength_index i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic bit idle_now(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    task automatic predict_rsi(input logic [SAMPLE_W-1:0] price, input logic series_start);
        longint unsigned n;
        longint          delta;
        logic [63:0]     up;
        logic [63:0]     down;
        logic [63:0]     total;
        bit              emit;
        rsi_result_t     res;
        emit = 1'b0;
        if (window_reg < MIN_WINDOW)
            n = MIN_WINDOW;
        else if (window_reg > MAX_WINDOW)
            n = MAX_WINDOW;
        else
            n = window_reg;
        if (series_start || series_len == 0)
        begin
            last_price = price;
            series_len = 1;
            gain_avg   = '0;
            loss_avg   = '0;
        end
        else
        begin
            delta      = longint'($signed(price)) - longint'(last_price);
            last_price = price;
            up         = (delta > 0) ? 64'(delta) : 64'd0;
            down       = (delta < 0) ? 64'(-delta) : 64'd0;
            if (series_len < n)
            begin
                // warm-up sums, first average once the window is full
                gain_avg += up;
                loss_avg += down;
                series_len++;
                if (series_len == n)
                begin
                    gain_avg = ((gain_avg << 16) / n) & AVG_MASK;
                    loss_avg = ((loss_avg << 16) / n) & AVG_MASK;
                    emit     = 1'b1;
                end
            end
            else
            begin
                gain_avg = ((gain_avg * (n - 1) + (up << 16)) / n) & AVG_MASK;
                loss_avg = ((loss_avg * (n - 1) + (down << 16)) / n) & AVG_MASK;
                emit     = 1'b1;
            end
        end
        if (emit)
        begin
            if (loss_avg == 0)
            begin
                res.rsi_value = RSI_FULL;
                res.no_loss   = 1'b1;
            end
            else
            begin
                total         = gain_avg + loss_avg;
                res.rsi_value = RSI_W'((64'(RSI_FULL) * gain_avg + total / 2) / total);
                res.no_loss   = 1'b0;
            end
            expected_rsi.insert(expected_rsi.size(), res);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_price(input logic [SAMPLE_W-1:0] prev,
                                                       input bit rising);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (rising)
            return prev + 32'($urandom_range(0, 32'h0004_0000));
        if (roll < 50)
            return prev + 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        if (roll < 62)
            return prev;
        if (roll < 74)
            return prev + 32'($urandom_range(1, 32'h0008_0000));
        if (roll < 90)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic push_sample(input logic [SAMPLE_W-1:0] price, input logic series_start,
                               input bit wait_drain = 1'b0);
        sample_req_t req;
        req.price        = price;
        req.series_start = series_start;
        req.wait_drain   = wait_drain;
        pending_samples.insert(pending_samples.size(), req);
        requests_queued++;
    endtask

    task automatic wait_for_drain();
        while (requests_accepted != requests_queued || expected_rsi.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        wait_for_drain();
        // the last request may still be in the pipe without a result
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        window_reg = value;
        series_len = 0;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [WIN_W-1:0] window, input int count,
                             input int send_pct, input int recv_pct, input bit rising,
                             input int start_pct, input int hold_at);
        logic [SAMPLE_W-1:0] price;
        write_window(window);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        price = rising ? '0 : $urandom;
        for (int i = 0; i < count; i++)
        begin
            if (i != 0)
                price = pick_price(price, rising);
            push_sample(price, $urandom_range(0, 99) < start_pct, i == hold_at);
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_rsi(s_axis_tdata, s_axis_tuser);
                requests_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_samples.size() != 0 && !idle_now(sender_idle_pct)
                    && (!pending_samples[0].wait_drain || expected_rsi.size() == 0))
                begin
                    next_request = pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_request.price;
                    s_axis_tuser  <= next_request.series_start;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= !idle_now(receiver_idle_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_rsi.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata, 0);
                else
                begin
                    next_expected = expected_rsi.pop_front();
                    if (m_axis_tdata[RSI_W-1:0] !== next_expected.rsi_value)
                        report_mismatch("rsi_value", m_axis_tdata[RSI_W-1:0],
                                        next_expected.rsi_value);
                    if (m_axis_tuser !== next_expected.no_loss)
                        report_mismatch("no_loss", m_axis_tuser, next_expected.no_loss);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CLOCK_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset window: flat series, then full-scale rise and fall
        repeat (14) push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);

        write_window(9'd2);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h1234_5678, 1'b1);
        push_sample(32'h1234_5678, 1'b0);
        push_sample(32'h1234_5677, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'h0000_0000, 1'b0);

        run_phase(9'd2,   40,  0,  0,  1'b0, 8,  25);
        run_phase(9'd0,   25,  50, 0,  1'b0, 10, -1);
        run_phase(9'd3,   25,  0,  50, 1'b1, 0,  -1);
        run_phase(9'd1,   20,  24, 24, 1'b0, 10, -1);
        run_phase(9'd7,   25,  50, 0,  1'b0, 6,  -1);
        run_phase(9'd511, 262, 24, 24, 1'b0, 0,  -1);
        run_phase(9'd14,  25,  0,  0,  1'b0, 5,  -1);

        wait_for_drain();
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: relative_strength_index.f
rtl/rsi_pkg.sv
rtl/rsi_divider.sv
rtl/relative_strength_index.sv
test/testbench.sv
